// ----- sv/tfn_pkg.sv -----
`default_nettype none

package tfn_pkg;

    localparam int COORD_BITS_DEF       = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // multiplier operand slice handled per pipeline stage
    localparam int MUL_CHUNK = 16;

    // x, y, z
    localparam int LANES = 3;

endpackage

`default_nettype wire

// ----- sv/tfn_cross.sv -----
`default_nettype none

module tfn_cross #(
    parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          en,
    input  wire logic                                          in_vld,
    input  wire logic signed [COORD_BITS-1:0]                  a_x,
    input  wire logic signed [COORD_BITS-1:0]                  a_y,
    input  wire logic signed [COORD_BITS-1:0]                  a_z,
    input  wire logic signed [COORD_BITS-1:0]                  b_x,
    input  wire logic signed [COORD_BITS-1:0]                  b_y,
    input  wire logic signed [COORD_BITS-1:0]                  b_z,
    input  wire logic signed [COORD_BITS-1:0]                  c_x,
    input  wire logic signed [COORD_BITS-1:0]                  c_y,
    input  wire logic signed [COORD_BITS-1:0]                  c_z,
    output logic                                               vld,
    output logic [tfn_pkg::LANES-1:0][2*COORD_BITS+1:0]        mag,
    output logic [tfn_pkg::LANES-1:0]                          neg,
    output logic                                               zero
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int RW = PW + 1;
    localparam int MW = PW;

    logic signed [COORD_BITS-1:0] av [3];
    logic signed [COORD_BITS-1:0] bv [3];
    logic signed [COORD_BITS-1:0] cv [3];

    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] v_reg [3];
    logic signed [PW-1:0] p_reg [6];
    logic [RW-1:0]        r_reg [3];
    logic [RW-1:0]        r_neg [3];

    logic [3:0] vld_reg;

    assign av[0] = a_x;
    assign av[1] = a_y;
    assign av[2] = a_z;
    assign bv[0] = b_x;
    assign bv[1] = b_y;
    assign bv[2] = b_z;
    assign cv[0] = c_x;
    assign cv[1] = c_y;
    assign cv[2] = c_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            r_neg[k] = '0 - r_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // edge vectors u = a - b, v = a - c
            for (int k = 0; k < 3; k++)
            begin
                u_reg[k] <= {av[k][COORD_BITS-1], av[k]} - {bv[k][COORD_BITS-1], bv[k]};
                v_reg[k] <= {av[k][COORD_BITS-1], av[k]} - {cv[k][COORD_BITS-1], cv[k]};
            end
            p_reg[0] <= u_reg[1] * v_reg[2];
            p_reg[1] <= v_reg[1] * u_reg[2];
            p_reg[2] <= v_reg[0] * u_reg[2];
            p_reg[3] <= u_reg[0] * v_reg[2];
            p_reg[4] <= u_reg[0] * v_reg[1];
            p_reg[5] <= v_reg[0] * u_reg[1];
            for (int k = 0; k < 3; k++)
            begin
                r_reg[k] <= {p_reg[2*k][PW-1], p_reg[2*k]}
                          - {p_reg[2*k+1][PW-1], p_reg[2*k+1]};
            end
            for (int k = 0; k < 3; k++)
            begin
                neg[k] <= r_reg[k][RW-1];
                mag[k] <= r_reg[k][RW-1] ? r_neg[k][MW-1:0] : r_reg[k][MW-1:0];
            end
            zero <= (r_reg[0] == '0) && (r_reg[1] == '0) && (r_reg[2] == '0);
        end
    end

    assign vld = vld_reg[3];

endmodule

`default_nettype wire

// ----- sv/tfn_square.sv -----
`default_nettype none

// three lanes of a*a, one operand slice per stage
module tfn_square #(
    parameter int W     = 34,
    parameter int SIDEW = 4
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire logic                                   in_vld,
    input  wire logic [tfn_pkg::LANES-1:0][W-1:0]       a,
    input  wire logic [SIDEW-1:0]                       in_side,
    output logic                                        vld,
    output logic [tfn_pkg::LANES-1:0][2*W-1:0]          sq,
    output logic [SIDEW-1:0]                            side
);

    localparam int CH  = tfn_pkg::MUL_CHUNK;
    localparam int NS  = (W + CH - 1) / CH;
    localparam int BP  = NS * CH;
    localparam int PW  = 2 * W;
    localparam int XW  = W + BP;
    localparam int AW2 = W + CH;
    localparam int L   = tfn_pkg::LANES;

    logic [W-1:0]     a_reg    [NS][L];
    logic [PW-1:0]    acc_reg  [NS][L];
    logic [SIDEW-1:0] side_reg [NS];
    logic [NS-1:0]    vld_reg;

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        for (genvar l = 0; l < L; l++)
        begin : g_lane
            logic [W-1:0]   a_src;
            logic [PW-1:0]  acc_src;
            logic [BP-1:0]  a_pad;
            logic [AW2-1:0] pp;
            logic [XW-1:0]  sum;

            if (k == 0)
            begin : g_first
                assign a_src   = a[l];
                assign acc_src = '0;
            end
            else
            begin : g_next
                assign a_src   = a_reg[k-1][l];
                assign acc_src = acc_reg[k-1][l];
            end

            assign a_pad = BP'(a_src);
            assign pp    = AW2'(a_src) * AW2'(a_pad[k*CH +: CH]);
            assign sum   = XW'(acc_src) + (XW'(pp) << (k * CH));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[k][l]   <= a_src;
                    acc_reg[k][l] <= sum[PW-1:0];
                end
            end
        end

        if (k == 0)
        begin : g_side0
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[k] <= in_side;
                end
            end
        end
        else
        begin : g_siden
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            if (NS > 1)
            begin
                vld_reg <= NS'({vld_reg, in_vld});
            end
            else
            begin
                vld_reg <= NS'(in_vld);
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            sq[l] = acc_reg[NS-1][l];
        end
    end

    assign vld  = vld_reg[NS-1];
    assign side = side_reg[NS-1];

endmodule

`default_nettype wire

// ----- sv/tfn_divider.sv -----
`default_nettype none

// restoring divider, one quotient bit per stage, three lanes on a shared divisor
// quotient = floor(num * 2^(QW-1) / den); requires num <= den
module tfn_divider #(
    parameter int NW    = 68,
    parameter int SW    = 70,
    parameter int QW    = 31,
    parameter int SIDEW = 4
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire logic                                   in_vld,
    input  wire logic [tfn_pkg::LANES-1:0][NW-1:0]      num,
    input  wire logic [SW-1:0]                          den,
    input  wire logic [SIDEW-1:0]                       in_side,
    output logic                                        vld,
    output logic [tfn_pkg::LANES-1:0][QW-1:0]           quo,
    output logic [SIDEW-1:0]                            side
);

    localparam int L = tfn_pkg::LANES;

    logic [SW-1:0]    rem_reg  [QW][L];
    logic [QW-1:0]    q_reg    [QW][L];
    logic [SW-1:0]    den_reg  [QW];
    logic [SIDEW-1:0] side_reg [QW];
    logic [QW-1:0]    vld_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        logic [SW-1:0] den_src;

        if (j == 0)
        begin : g_d0
            assign den_src = den;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[j] <= in_side;
                end
            end
        end
        else
        begin : g_dn
            assign den_src = den_reg[j-1];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[j] <= side_reg[j-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[j] <= den_src;
            end
        end

        for (genvar l = 0; l < L; l++)
        begin : g_lane
            logic [SW-1:0] rem_src;
            logic [QW-1:0] q_src;
            logic          bit_in;
            logic [SW:0]   shifted;
            logic [SW:0]   diff;
            logic          ge;

            if (j == 0)
            begin : g_first
                assign rem_src = SW'(num[l][NW-1:1]);
                assign bit_in  = num[l][0];
                assign q_src   = '0;
            end
            else
            begin : g_next
                assign rem_src = rem_reg[j-1][l];
                assign bit_in  = 1'b0;
                assign q_src   = q_reg[j-1][l];
            end

            assign shifted = {rem_src, bit_in};
            assign ge      = shifted >= {1'b0, den_src};
            assign diff    = shifted - {1'b0, den_src};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j][l] <= ge ? diff[SW-1:0] : shifted[SW-1:0];
                    q_reg[j][l]   <= {q_src[QW-2:0], ge};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QW-2:0], in_vld};
        end
    end

    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            quo[l] = q_reg[QW-1][l];
        end
    end

    assign vld  = vld_reg[QW-1];
    assign side = side_reg[QW-1];

endmodule

`default_nettype wire

// ----- sv/tfn_isqrt.sv -----
`default_nettype none

// digit-by-digit integer square root, one root bit per stage, three lanes
module tfn_isqrt #(
    parameter int QW    = 31,
    parameter int RT    = 16,
    parameter int SIDEW = 4
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire logic                                   in_vld,
    input  wire logic [tfn_pkg::LANES-1:0][QW-1:0]      rad,
    input  wire logic [SIDEW-1:0]                       in_side,
    output logic                                        vld,
    output logic [tfn_pkg::LANES-1:0][RT-1:0]           root,
    output logic [SIDEW-1:0]                            side
);

    localparam int L  = tfn_pkg::LANES;
    localparam int QP = 2 * RT;
    localparam int RM = RT + 2;

    logic [QP-1:0]    rad_reg  [RT][L];
    logic [RM-1:0]    rem_reg  [RT][L];
    logic [RT-1:0]    root_reg [RT][L];
    logic [SIDEW-1:0] side_reg [RT];
    logic [RT-1:0]    vld_reg;

    for (genvar j = 0; j < RT; j++)
    begin : g_stage
        if (j == 0)
        begin : g_s0
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[j] <= in_side;
                end
            end
        end
        else
        begin : g_sn
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[j] <= side_reg[j-1];
                end
            end
        end

        for (genvar l = 0; l < L; l++)
        begin : g_lane
            logic [QP-1:0] rad_src;
            logic [RM-1:0] rem_src;
            logic [RT-1:0] root_src;
            logic [RM+1:0] shifted;
            logic [RM+1:0] trial;
            logic [RM+1:0] diff;
            logic          ge;

            if (j == 0)
            begin : g_first
                assign rad_src  = QP'(rad[l]);
                assign rem_src  = '0;
                assign root_src = '0;
            end
            else
            begin : g_next
                assign rad_src  = rad_reg[j-1][l];
                assign rem_src  = rem_reg[j-1][l];
                assign root_src = root_reg[j-1][l];
            end

            assign shifted = {rem_src, rad_src[QP-1-2*j -: 2]};
            assign trial   = (RM+2)'({root_src, 2'b01});
            assign ge      = shifted >= trial;
            assign diff    = shifted - trial;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[j][l]  <= rad_src;
                    rem_reg[j][l]  <= ge ? diff[RM-1:0] : shifted[RM-1:0];
                    root_reg[j][l] <= {root_src[RT-2:0], ge};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[RT-2:0], in_vld};
        end
    end

    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            root[l] = root_reg[RT-1][l];
        end
    end

    assign vld  = vld_reg[RT-1];
    assign side = side_reg[RT-1];

endmodule

`default_nettype wire

// ----- sv/triangle_face_normal.sv -----
// Throughput: one triangle per cycle; every stage advances together, and the whole
//   pipeline holds while a finished result waits at the output register.
// Per component: q = floor(r^2 * 2^(2F+2) / |r|^2) on a bit-per-stage divider,
//   then an integer square root, one bit per stage, is halved with rounding to give the magnitude.
// Reset clears all valid bits; no result is pending afterwards.
`default_nettype none

module triangle_face_normal #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [COORD_BITS-1:0]        a_x,
    input  wire logic signed [COORD_BITS-1:0]        a_y,
    input  wire logic signed [COORD_BITS-1:0]        a_z,
    input  wire logic signed [COORD_BITS-1:0]        b_x,
    input  wire logic signed [COORD_BITS-1:0]        b_y,
    input  wire logic signed [COORD_BITS-1:0]        b_z,
    input  wire logic signed [COORD_BITS-1:0]        c_x,
    input  wire logic signed [COORD_BITS-1:0]        c_y,
    input  wire logic signed [COORD_BITS-1:0]        c_z,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [NORMAL_FRAC_BITS+1:0]       normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0]       normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0]       normal_z,
    output logic                                     degenerate
);

    localparam int L     = tfn_pkg::LANES;
    localparam int MW    = 2 * COORD_BITS + 2;
    localparam int SQW   = 2 * MW;
    localparam int SW    = SQW + 2;
    localparam int QW    = 2 * NORMAL_FRAC_BITS + 3;
    localparam int RT    = NORMAL_FRAC_BITS + 2;
    localparam int OW    = NORMAL_FRAC_BITS + 2;
    localparam int SIDEW = L + 1;

    logic en;

    logic                  cr_vld;
    logic [L-1:0][MW-1:0]  cr_mag;
    logic [L-1:0]          cr_neg;
    logic                  cr_zero;

    logic                  sq_vld;
    logic [L-1:0][SQW-1:0] sq;
    logic [SIDEW-1:0]      sq_side;

    logic                  sum_vld_reg;
    logic [L-1:0][SQW-1:0] sum_sq_reg;
    logic [SW-1:0]         sum_s_reg;
    logic [SIDEW-1:0]      sum_side_reg;

    logic                  dv_vld;
    logic [L-1:0][QW-1:0]  dv_quo;
    logic [SIDEW-1:0]      dv_side;

    logic                  rt_vld;
    logic [L-1:0][RT-1:0]  rt_root;
    logic [SIDEW-1:0]      rt_side;

    logic [L-1:0][OW-1:0]  comp_next;
    logic [L-1:0][OW-1:0]  comp_reg;
    logic                  degenerate_reg;
    logic                  out_vld_reg;

    // single stall point: the whole pipe moves unless the output is held
    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    tfn_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (in_valid),
        .a_x    (a_x),
        .a_y    (a_y),
        .a_z    (a_z),
        .b_x    (b_x),
        .b_y    (b_y),
        .b_z    (b_z),
        .c_x    (c_x),
        .c_y    (c_y),
        .c_z    (c_z),
        .vld    (cr_vld),
        .mag    (cr_mag),
        .neg    (cr_neg),
        .zero   (cr_zero)
    );

    tfn_square #(
        .W     (MW),
        .SIDEW (SIDEW)
    ) u_square (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (cr_vld),
        .a       (cr_mag),
        .in_side ({cr_zero, cr_neg}),
        .vld     (sq_vld),
        .sq      (sq),
        .side    (sq_side)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sum_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_sq_reg   <= sq;
            sum_s_reg    <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
            sum_side_reg <= sq_side;
        end
    end

    tfn_divider #(
        .NW    (SQW),
        .SW    (SW),
        .QW    (QW),
        .SIDEW (SIDEW)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (sum_vld_reg),
        .num     (sum_sq_reg),
        .den     (sum_s_reg),
        .in_side (sum_side_reg),
        .vld     (dv_vld),
        .quo     (dv_quo),
        .side    (dv_side)
    );

    tfn_isqrt #(
        .QW    (QW),
        .RT    (RT),
        .SIDEW (SIDEW)
    ) u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (dv_vld),
        .rad     (dv_quo),
        .in_side (dv_side),
        .vld     (rt_vld),
        .root    (rt_root),
        .side    (rt_side)
    );

    // n = (isqrt(q) + 1) / 2 gives round-to-nearest, ties away from zero
    always_comb
    begin
        logic [RT:0]   inc;
        logic [OW-1:0] n;
        for (int l = 0; l < L; l++)
        begin
            inc = {1'b0, rt_root[l]} + (RT+1)'(1);
            n   = OW'(inc[RT:1]);
            if (rt_side[L])
            begin
                comp_next[l] = '0;
            end
            else if (rt_side[l])
            begin
                comp_next[l] = '0 - n;
            end
            else
            begin
                comp_next[l] = n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= rt_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            comp_reg       <= comp_next;
            degenerate_reg <= rt_side[L];
        end
    end

    assign out_valid  = out_vld_reg;
    assign normal_x   = comp_reg[0];
    assign normal_y   = comp_reg[1];
    assign normal_z   = comp_reg[2];
    assign degenerate = degenerate_reg;

endmodule

`default_nettype wire

// ----- sv/tfn_checker.sv -----
`default_nettype none

module tfn_checker #(
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_ready,
    input wire logic                                 out_valid,
    input wire logic                                 out_ready,
    input wire logic signed [NORMAL_FRAC_BITS+1:0]   normal_x,
    input wire logic signed [NORMAL_FRAC_BITS+1:0]   normal_y,
    input wire logic signed [NORMAL_FRAC_BITS+1:0]   normal_z,
    input wire logic                                 degenerate
);

    localparam logic signed [NORMAL_FRAC_BITS+1:0] ONE =
        (NORMAL_FRAC_BITS+2)'(1) <<< NORMAL_FRAC_BITS;

    logic in_range;
    logic all_zero;

    assign in_range = (normal_x <= ONE) && (normal_x >= -ONE)
                   && (normal_y <= ONE) && (normal_y >= -ONE)
                   && (normal_z <= ONE) && (normal_z >= -ONE);
    assign all_zero = (normal_x == '0) && (normal_y == '0) && (normal_z == '0);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y)
            && $stable(normal_z) && $stable(degenerate))
        else $error("result changed before transfer");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> all_zero)
        else $error("degenerate result carries a nonzero normal");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_range)
        else $error("normal component outside unit range");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while pipeline is held");

endmodule

bind triangle_face_normal tfn_checker #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tfn_checker (.*);

`default_nettype wire

// ----- tb/triangle_face_normal_checker.sv -----
`default_nettype none

module triangle_face_normal_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic signed [15:0] a_x,
    input  wire logic signed [15:0] a_y,
    input  wire logic signed [15:0] a_z,
    input  wire logic signed [15:0] b_x,
    input  wire logic signed [15:0] b_y,
    input  wire logic signed [15:0] b_z,
    input  wire logic signed [15:0] c_x,
    input  wire logic signed [15:0] c_y,
    input  wire logic signed [15:0] c_z,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [15:0] normal_x,
    input  wire logic signed [15:0] normal_y,
    input  wire logic signed [15:0] normal_z,
    input  wire logic               degenerate,
    output int                      fail_count,
    output int                      normals_pending,
    output int                      normals_seen,
    output int                      degenerate_seen
);

    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        degen;
    } face_normal_t;

    face_normal_t expected_normals[$];

    // round(|r| * 2^14 / sqrt(s)), ties away from zero, bit by bit
    function automatic logic [15:0] unit_component(logic [127:0] r_sq, logic [127:0] s);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [127:0] odd;
        logic [15:0]  n;
        logic [15:0]  t;
        rhs = r_sq << 30;
        n = '0;
        for (int b = 14; b >= 0; b--)
        begin
            t = n | (16'd1 << b);
            odd = 128'(2 * t - 1);
            lhs = odd * odd * s;
            if (lhs <= rhs)
                n = t;
        end
        return n;
    endfunction

    function automatic face_normal_t predict_normal(
        logic signed [15:0] ax, logic signed [15:0] ay, logic signed [15:0] az,
        logic signed [15:0] bx, logic signed [15:0] by, logic signed [15:0] bz,
        logic signed [15:0] cx, logic signed [15:0] cy, logic signed [15:0] cz);
        longint       u[3];
        longint       v[3];
        longint       r[3];
        logic [127:0] mag[3];
        logic [127:0] s;
        logic [15:0]  n;
        face_normal_t res;
        u[0] = longint'(ax) - longint'(bx);
        u[1] = longint'(ay) - longint'(by);
        u[2] = longint'(az) - longint'(bz);
        v[0] = longint'(ax) - longint'(cx);
        v[1] = longint'(ay) - longint'(cy);
        v[2] = longint'(az) - longint'(cz);
        r[0] = u[1] * v[2] - v[1] * u[2];
        r[1] = v[0] * u[2] - u[0] * v[2];
        r[2] = u[0] * v[1] - v[0] * u[1];
        s = '0;
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = 128'(r[k] < 0 ? -r[k] : r[k]);
            s = s + mag[k] * mag[k];
        end
        res = '0;
        if (s == 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        for (int k = 0; k < 3; k++)
        begin
            n = unit_component(mag[k] * mag[k], s);
            if (r[k] < 0)
                n = -n;
            if (k == 0) res.nx = n;
            else if (k == 1) res.ny = n;
            else res.nz = n;
        end
        return res;
    endfunction

    assign normals_pending = expected_normals.size();

    always @(posedge clk or negedge rst_n)
    begin
        face_normal_t want;
        if (!rst_n)
        begin
            fail_count      <= 0;
            normals_seen    <= 0;
            degenerate_seen <= 0;
            expected_normals.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                expected_normals.push_back(predict_normal(a_x, a_y, a_z, b_x, b_y, b_z,
                                                          c_x, c_y, c_z));
            if (out_valid && out_ready)
            begin
                normals_seen <= normals_seen + 1;
                if (degenerate)
                    degenerate_seen <= degenerate_seen + 1;
                if (expected_normals.size() == 0)
                begin
                    $error("unexpected result transfer");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_normals.pop_front();
                    if (normal_x !== want.nx || normal_y !== want.ny ||
                        normal_z !== want.nz || degenerate !== want.degen)
                    begin
                        fail_count <= fail_count + 1;
                        if (normal_x !== want.nx)
                            $error("normal_x expected %0d got %0d",
                                   $signed(want.nx), normal_x);
                        if (normal_y !== want.ny)
                            $error("normal_y expected %0d got %0d",
                                   $signed(want.ny), normal_y);
                        if (normal_z !== want.nz)
                            $error("normal_z expected %0d got %0d",
                                   $signed(want.nz), normal_z);
                        if (degenerate !== want.degen)
                            $error("degenerate expected %0b got %0b", want.degen, degenerate);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/triangle_face_normal_tb.sv -----
`default_nettype none

module triangle_face_normal_tb;

    localparam int RANDOM_TRIANGLES = 1330;
    localparam int QUIET_TAIL       = 200;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 70;

    typedef enum int {
        SHAPE_ANY,
        SHAPE_TIGHT,
        SHAPE_COLLINEAR,
        SHAPE_FLAT_Z,
        SHAPE_FLAT_X
    } tri_shape_e;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic               degenerate;

    int  fail_count;
    int  normals_pending;
    int  normals_seen;
    int  degenerate_seen;
    int  cycle_count;
    int  triangles_sent;
    bit  quiet;

    triangle_face_normal u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_x(a_x), .a_y(a_y), .a_z(a_z),
        .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .c_x(c_x), .c_y(c_y), .c_z(c_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .degenerate(degenerate)
    );

    triangle_face_normal_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_x(a_x), .a_y(a_y), .a_z(a_z),
        .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .c_x(c_x), .c_y(c_y), .c_z(c_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .degenerate(degenerate),
        .fail_count(fail_count), .normals_pending(normals_pending),
        .normals_seen(normals_seen), .degenerate_seen(degenerate_seen)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL triangle_face_normal");
            $finish;
        end
    end

    // receiver back-pressure in bursts
    always @(posedge clk)
    begin
        int stall;
        if (quiet || !rst_n)
            out_ready <= 1'b1;
        else if (stall > 0)
        begin
            stall = stall - 1;
            out_ready <= (stall == 0);
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall = $urandom_range(1, 8);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_triangle(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                 logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
                                 logic [15:0] cx, logic [15:0] cy, logic [15:0] cz);
        int gap;
        gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        a_x <= ax; a_y <= ay; a_z <= az;
        b_x <= bx; b_y <= by; b_z <= bz;
        c_x <= cx; c_y <= cy; c_z <= cz;
        // in_ready is settled by the falling edge
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        triangles_sent++;
    endtask

    function automatic logic [15:0] near(logic [15:0] base, int spread);
        return base + 16'($urandom_range(0, 2 * spread) - spread);
    endfunction

    task automatic send_random_triangle();
        tri_shape_e   shape;
        logic [15:0]  ax, ay, az, dx, dy, dz;
        int           k;
        shape = tri_shape_e'($urandom_range(0, 4));
        ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
        case (shape)
            SHAPE_ANY:
                send_triangle(ax, ay, az, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom));
            SHAPE_TIGHT:
                send_triangle(ax, ay, az, near(ax, 300), near(ay, 300), near(az, 300),
                              near(ax, 300), near(ay, 300), near(az, 300));
            SHAPE_COLLINEAR:
            begin
                ax = 16'($urandom_range(0, 16000) - 8000);
                ay = 16'($urandom_range(0, 16000) - 8000);
                az = 16'($urandom_range(0, 16000) - 8000);
                dx = 16'($urandom_range(0, 2000) - 1000);
                dy = 16'($urandom_range(0, 2000) - 1000);
                dz = 16'($urandom_range(0, 2000) - 1000);
                k = $urandom_range(0, 6) - 3;
                send_triangle(ax, ay, az, ax + dx, ay + dy, az + dz,
                              ax + 16'(k) * dx, ay + 16'(k) * dy, az + 16'(k) * dz);
            end
            SHAPE_FLAT_Z:
                send_triangle(ax, ay, az, 16'($urandom), 16'($urandom), az,
                              16'($urandom), 16'($urandom), az);
            default:
                send_triangle(ax, ay, az, ax, 16'($urandom), 16'($urandom),
                              ax, 16'($urandom), 16'($urandom));
        endcase
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b1;
        quiet = 1'b0;
        cycle_count = 0;
        triangles_sent = 0;
        {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all coincident, collinear
        send_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_triangle(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                      16'h8000, 16'h8000, 16'h8000);
        send_triangle(0, 0, 0, 256, 256, 256, 512, 512, 512);
        send_triangle(16'h7fff, 0, 0, 16'h8000, 0, 0, 0, 0, 0);
        // axis aligned normals, both signs
        send_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0);
        send_triangle(0, 0, 0, 0, 256, 0, 256, 0, 0);
        send_triangle(0, 0, 0, 0, 256, 0, 0, 0, 256);
        send_triangle(0, 0, 0, 0, 0, 256, 0, 256, 0);
        send_triangle(0, 0, 0, 0, 0, 256, 256, 0, 0);
        send_triangle(0, 0, 0, 256, 0, 0, 0, 0, 256);
        // full-range corners
        send_triangle(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                      16'h8000, 16'h7fff, 16'h8000);
        send_triangle(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                      16'h8000, 16'h7fff, 16'h8000);
        send_triangle(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                      16'h7fff, 16'h7fff, 16'h8000);
        send_triangle(16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h8000, 16'h0001,
                      16'h8000, 16'h0001, 16'h7fff);
        // smallest nonzero edges, axis aligned and diagonal normals
        send_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0);
        send_triangle(0, 0, 0, 1, 16'hffff, 0, 0, 1, 16'hffff);
        send_triangle(100, 200, 300, 101, 201, 300, 100, 201, 301);

        for (int i = 0; i < RANDOM_TRIANGLES; i++)
        begin
            if (i == RANDOM_TRIANGLES - QUIET_TAIL)
                quiet = 1'b1;
            send_random_triangle();
        end
        in_valid <= 1'b0;

        while (normals_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d triangles (directed corners, random, tight, collinear, flat)",
                 triangles_sent);
        $display("Checked %0d normals, %0d of them degenerate", normals_seen, degenerate_seen);
        if (fail_count == 0)
            $display("PASS triangle_face_normal");
        else
            $display("FAIL triangle_face_normal");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/tfn_pkg.sv
sv/tfn_cross.sv
sv/tfn_square.sv
sv/tfn_divider.sv
sv/tfn_isqrt.sv
sv/triangle_face_normal.sv
sv/tfn_checker.sv
tb/triangle_face_normal_checker.sv
tb/triangle_face_normal_tb.sv
